// ===== hdl/wstl_pkg.sv =====
// Shared types and constants for the wheel speed throttle loop.
package wstl_pkg;

  localparam int unsigned ElapsedW = 28;
  localparam logic [27:0] ElapsedMax = 28'hFFFFFFF;
  localparam logic [27:0] OverflowTime = 28'd32000;
  localparam logic [15:0] CaptureBase = 16'h0600;
  localparam logic [15:0] DistStep = 16'd14;
  localparam logic [31:0] SpeedNum = 32'd207000000;
  localparam logic [31:0] RateNum = 32'd207000;
  localparam int unsigned DivW = 32;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_R_EDGE  = 3'd1,
    ACT_L_EDGE  = 3'd2,
    ACT_R_OVF   = 3'd3,
    ACT_L_OVF   = 3'd4,
    ACT_CLEAR   = 3'd5,
    ACT_RSVD6   = 3'd6,
    ACT_RSVD7   = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    REG_LIMIT  = 3'd0,
    REG_REV    = 3'd1,
    REG_FWD    = 3'd2,
    REG_SLOW   = 3'd3,
    REG_THRESH = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        capture_count;
    logic signed [15:0] target_left_speed;
    logic signed [15:0] target_right_speed;
  } req_t;

  typedef struct packed {
    logic [7:0]         pwm_left;
    logic [7:0]         pwm_right;
    logic signed [7:0]  throttle_left_out;
    logic signed [7:0]  throttle_right_out;
    logic signed [15:0] speed_left_out;
    logic signed [15:0] speed_right_out;
    logic [15:0]        distance_left_out;
    logic [15:0]        distance_right_out;
    logic               throttle_updated;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, do single-cycle work
    logic div_start; // start divider for edge or rate
    logic div_done_apply;
    logic map_start;
    logic map_apply;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_busy;
  } sts_t;

endpackage

// ===== hdl/wheel_speed_throttle_loop.sv =====
// Top level of the two-wheel speed regulator.
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with payload in_data_i: one
//   event each (ms tick, encoder edge, timer overflow, distance clear).
//   Every request yields exactly one result on out_valid_o/out_ready_i,
//   carrying PWM, throttles, speeds, distances and the update flag.
//   The result is formed by the shared 32-step divider, which computes
//   speed or update interval, followed by the two PWM map divisions,
//   and is then presented. One request is in flight at a time: the
//   block takes no new request until the result has been handed off.
//   The result is held in registers; while the receiver stalls the
//   block holds it and takes no new request.
//   Reset clears all wheel state and loads register defaults; the block
//   is ready in the first cycle after reset.
//   Configuration writes via cfg_we_i/cfg_idx_i/cfg_data_i while idle.
module wheel_speed_throttle_loop (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wstl_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wstl_pkg::rsp_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);
  import wstl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wstl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  wstl_dp u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .rsp_o(out_data_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );
endmodule

// ===== hdl/wstl_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module wstl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [35:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);
  import wstl_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [36:0] rem_q, rem_d;
  logic [35:0] den_q, den_d;
  logic [36:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = '0;
    if (start_i) begin
      cnt_d = 6'(DivW);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != 6'd0) begin
      trial = {rem_q[35:0], quo_q[31]} - {1'b0, den_q};
      if (!trial[36]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[35:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quo_o  = quo_q;
endmodule

// ===== hdl/wstl_dp.sv =====
// Datapath: wheel state, edge and tick arithmetic, PWM mapping.
module wstl_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wstl_pkg::req_t      req_i,
  input  wstl_pkg::cmd_t      cmd_i,
  output wstl_pkg::sts_t      sts_o,
  output wstl_pkg::rsp_t      rsp_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import wstl_pkg::*;

  logic [6:0]  lim_q;
  logic [7:0]  rev_q, fwd_q;
  logic [15:0] slow_q;
  logic [9:0]  thr_q;

  logic [31:0] ms_q, nxt_q;
  logic signed [7:0] tl_q, tr_q;
  logic [27:0] el_q, er_q;
  logic signed [15:0] sl_q, sr_q;
  logic [15:0] dl_q, dr_q;
  logic        upd_q;
  req_t        r_q;
  req_t        cur;
  logic        is_tick_q;
  logic        use_slow_q;

  // divider
  logic        div_busy;
  logic [31:0] div_num, quo;
  logic [35:0] div_den;

  wstl_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(quo)
  );

  // request-level combinational terms
  action_e act;
  logic [15:0] half;
  logic [27:0] e_sel;
  logic [28:0] e_sum;
  logic [15:0] al, ar;
  logic [16:0] asum;
  logic [31:0] ms_inc;
  logic signed [8:0] stl, str;
  logic signed [7:0] lim_s;
  logic        due;
  logic [15:0] spd_mag;

  function automatic logic signed [7:0] clampf(logic signed [8:0] v, logic signed [7:0] l);
    logic signed [8:0] l9;
    l9 = {l[7], l};
    if (v > l9) return l;
    if (v < -l9) return -l;
    return v[7:0];
  endfunction

  function automatic logic [15:0] absf(logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  assign cur    = cmd_i.load ? req_i : r_q;
  assign act    = action_e'(cur.action);
  assign half   = (cur.capture_count > CaptureBase) ?
                  16'((cur.capture_count - CaptureBase) >> 1) : 16'd0;
  assign e_sel  = (act == ACT_R_EDGE) ? er_q : el_q;
  assign e_sum  = {1'b0, e_sel} + {13'd0, half};
  assign al     = absf(cur.target_left_speed);
  assign ar     = absf(cur.target_right_speed);
  assign asum   = {1'b0, al} + {1'b0, ar};
  assign ms_inc = ms_q + 32'd1;
  assign due    = (act == ACT_TICK) && (nxt_q < ms_inc);
  assign lim_s  = {1'b0, lim_q};
  assign stl = (cur.target_left_speed > 16'(signed'(sl_q))) ? 9'(tl_q) + 9'sd1 :
               (cur.target_left_speed < sl_q) ? 9'(tl_q) - 9'sd1 : 9'(tl_q);
  assign str = (cur.target_right_speed > sr_q) ? 9'(tr_q) + 9'sd1 :
               (cur.target_right_speed < sr_q) ? 9'(tr_q) - 9'sd1 : 9'(tr_q);
  assign spd_mag = (e_sum == 29'd0 || quo > 32'd32767) ? 16'h7FFF : quo[15:0];

  // divisor: edge 15*e, tick 15*(sum/2)
  logic [35:0] p_edge;
  logic [35:0] p_rate;
  assign p_edge = 36'(e_sum) * 36'd15;
  assign p_rate = 36'(asum[16:1]) * 36'd15;

  always_comb begin
    if (is_tick_q) begin
      div_num = RateNum;
      div_den = p_rate;
    end else begin
      div_num = SpeedNum;
      div_den = p_edge;
    end
  end

  assign sts_o.need_div = 1'b1;
  assign sts_o.div_busy = div_busy;

  // pwm map: (x+L)*(b-a) / (2L) + a, truncated toward zero
  logic        map_busy;
  logic [5:0]  mcnt_q;
  logic        msel_q;
  logic signed [17:0] mprod;
  logic        mneg_q;
  logic [16:0] mquo_q;
  logic [17:0] mrem_q;
  logic [7:0]  pwml_q, pwmr_q;
  logic signed [8:0] mx;
  logic signed [8:0] mdiff;
  logic [17:0] mtrial;
  logic [8:0]  mden;

  assign mx    = msel_q ? 9'(clampf(9'(tr_q), lim_s)) + 9'(lim_s) :
                          9'(clampf(-9'(tl_q), lim_s)) + 9'(lim_s);
  assign mdiff = 9'({1'b0, fwd_q}) - 9'({1'b0, rev_q});
  assign mprod = 18'(mx) * 18'(mdiff);
  assign mden  = {1'b0, lim_q, 1'b0};
  assign mtrial = {mrem_q[16:0], mquo_q[16]} - {9'd0, mden};
  assign map_busy = (mcnt_q != 6'd0);

  logic [7:0] mres;
  assign mres = 8'((mneg_q ? -{1'b0, mquo_q} : {1'b0, mquo_q})) + rev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= 7'd100; rev_q <= 8'd62; fwd_q <= 8'd125;
      slow_q <= 16'd500; thr_q <= 10'd2;
      ms_q <= '0; nxt_q <= '0; tl_q <= '0; tr_q <= '0;
      el_q <= '0; er_q <= '0; sl_q <= '0; sr_q <= '0;
      dl_q <= '0; dr_q <= '0; upd_q <= 1'b0; r_q <= '0;
      is_tick_q <= 1'b0; use_slow_q <= 1'b0;
      mcnt_q <= '0; msel_q <= 1'b0;
      pwml_q <= 8'd62; pwmr_q <= 8'd62;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LIMIT:  lim_q  <= cfg_data_i[6:0];
          REG_REV:    rev_q  <= cfg_data_i[7:0];
          REG_FWD:    fwd_q  <= cfg_data_i[7:0];
          REG_SLOW:   slow_q <= cfg_data_i;
          REG_THRESH: thr_q  <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        r_q <= req_i;
        upd_q <= due;
        is_tick_q <= due;
        unique case (act)
          ACT_TICK: begin
            ms_q <= ms_inc;
            if (due) begin
              tl_q <= clampf(stl, lim_s);
              tr_q <= clampf(str, lim_s);
              use_slow_q <= ((al < {6'd0, thr_q}) && (ar < {6'd0, thr_q})) ||
                            (asum[16:1] == 16'd0);
              nxt_q <= ms_inc;
            end
          end
          ACT_R_EDGE: dr_q <= (dr_q > 16'hFFFF - DistStep) ? 16'hFFFF : dr_q + DistStep;
          ACT_L_EDGE: dl_q <= (dl_q > 16'hFFFF - DistStep) ? 16'hFFFF : dl_q + DistStep;
          ACT_R_OVF:  er_q <= (er_q > ElapsedMax - OverflowTime) ? ElapsedMax : er_q + OverflowTime;
          ACT_L_OVF:  el_q <= (el_q > ElapsedMax - OverflowTime) ? ElapsedMax : el_q + OverflowTime;
          ACT_CLEAR: begin
            dl_q <= '0; dr_q <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.div_done_apply) begin
        if (is_tick_q) begin
          nxt_q <= nxt_q + (use_slow_q ? {16'd0, slow_q} : quo);
        end else if (act == ACT_R_EDGE) begin
          sr_q <= tr_q[7] ? -spd_mag : spd_mag; er_q <= '0;
        end else if (act == ACT_L_EDGE) begin
          sl_q <= tl_q[7] ? -spd_mag : spd_mag; el_q <= '0;
        end
      end
      if (cmd_i.map_start) begin
        mcnt_q <= 6'd19; msel_q <= 1'b0;
      end else if (map_busy) begin
        if (mcnt_q == 6'd1 && !msel_q) begin
          mcnt_q <= 6'd19;
        end else begin
          mcnt_q <= mcnt_q - 6'd1;
        end
        if (mcnt_q == 6'd1) begin
          if (!msel_q) begin
            pwml_q <= mres;
            msel_q <= 1'b1;
          end else begin
            pwmr_q <= mres;
          end
        end
      end
      if (cmd_i.map_apply && lim_q == 7'd0) begin
        pwml_q <= rev_q; pwmr_q <= rev_q;
      end
    end
  end

  // map divider payload: load operand at count 19, iterate 17 steps, hold at count 1
  always_ff @(posedge clk_i) begin
    if (map_busy && mcnt_q == 6'd19) begin
      mneg_q <= mprod[17];
      mquo_q <= mprod[17] ? 17'(-mprod) : 17'(mprod);
      mrem_q <= '0;
    end else if (map_busy && mcnt_q != 6'd1) begin
      if (!mtrial[17]) begin
        mrem_q <= mtrial;
        mquo_q <= {mquo_q[15:0], 1'b1};
      end else begin
        mrem_q <= {mrem_q[16:0], mquo_q[16]};
        mquo_q <= {mquo_q[15:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp_o.pwm_left           = pwml_q;
    rsp_o.pwm_right          = pwmr_q;
    rsp_o.throttle_left_out  = tl_q;
    rsp_o.throttle_right_out = tr_q;
    rsp_o.speed_left_out     = sl_q;
    rsp_o.speed_right_out    = sr_q;
    rsp_o.distance_left_out  = dl_q;
    rsp_o.distance_right_out = dr_q;
    rsp_o.throttle_updated   = upd_q;
  end
endmodule

// ===== hdl/wstl_ctrl.sv =====
// Controller: sequences capture, divide, PWM mapping and result handoff.
module wstl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wstl_pkg::cmd_t cmd_o,
  input  wstl_pkg::sts_t sts_i
);
  import wstl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DSTART, S_DWAIT, S_MSTART, S_MWAIT, S_OUT
  } state_e;

  state_e st_q;
  logic [5:0] wcnt_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (st_q == S_IDLE) && in_valid_i;
    cmd_o.div_start = (st_q == S_DSTART);
    cmd_o.div_done_apply = (st_q == S_DWAIT) && !sts_i.div_busy;
    cmd_o.map_start = (st_q == S_MSTART);
    cmd_o.map_apply = (st_q == S_MWAIT) && (wcnt_q == 6'd0);
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      wcnt_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE:   if (in_valid_i) st_q <= sts_i.need_div ? S_DSTART : S_MSTART;
        S_DSTART: st_q <= S_DWAIT;
        S_DWAIT:  if (!sts_i.div_busy) st_q <= S_MSTART;
        S_MSTART: begin
          st_q <= S_MWAIT; wcnt_q <= 6'd38;
        end
        S_MWAIT: begin
          if (wcnt_q == 6'd0) st_q <= S_OUT;
          else wcnt_q <= wcnt_q - 6'd1;
        end
        S_OUT:    if (out_ready_i) st_q <= S_IDLE;
        default:  st_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== verif/tb_wheel_speed_throttle_loop.sv =====
// Testbench for the wheel speed throttle loop: random and directed events checked against a predictor.
`timescale 1ns / 100ps
module tb_wheel_speed_throttle_loop;
  import wstl_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  wheel_speed_throttle_loop dut (.*);

  initial forever #5 clk_i = ~clk_i;

  int unsigned lim_q, rev_q, fwd_q, slow_q, thr_q;
  logic [31:0] ms_q, next_q;
  int thl_q, thr_r_q, spl_q, spr_q;
  logic [27:0] el_q, er_q;
  int unsigned dl_q, dr_q;

  rsp_t wheel_rsp_q[$];
  int mismatches = 0;
  int unsigned idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic int clamp_throttle(int v);
    int l;
    l = int'(lim_q);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic logic [7:0] pwm_of(int x);
    int l, a, b, y;
    l = int'(lim_q);
    a = int'(rev_q);
    b = int'(fwd_q);
    if (l == 0) return a[7:0];
    x = clamp_throttle(x);
    y = ((x + l) * (b - a)) / (2 * l) + a;
    return y[7:0];
  endfunction

  function automatic int abs_i(int v);
    return v < 0 ? -v : v;
  endfunction

  task automatic measure_wheel(inout logic [27:0] el, inout int sp, inout int unsigned d,
                               input int th, input logic [15:0] cap);
    longint unsigned half, p, mag;
    half = cap > CaptureBase ? (cap - CaptureBase) / 2 : 0;
    p = (longint'(el) + half) * 15;
    mag = p == 0 ? 32767 : 64'd207000000 / p;
    if (mag > 32767) mag = 32767;
    sp = th < 0 ? -int'(mag) : int'(mag);
    d = d + 14 > 65535 ? 65535 : d + 14;
    el = '0;
  endtask

  function automatic logic [27:0] add_overflow(logic [27:0] el);
    return el > ElapsedMax - OverflowTime ? ElapsedMax : el + OverflowTime;
  endfunction

  function automatic int step_throttle(int th, int tgt, int sp);
    if (tgt > sp) th++;
    else if (tgt < sp) th--;
    return clamp_throttle(th);
  endfunction

  task automatic predict_wheels(req_t r);
    rsp_t e;
    int tl, tr, al, ar;
    int unsigned rate, dv;
    logic upd;
    upd = 1'b0;
    case (action_e'(r.action))
      ACT_TICK: begin
        ms_q = ms_q + 1;
        if (next_q < ms_q) begin
          tl = r.target_left_speed;
          tr = r.target_right_speed;
          al = abs_i(tl);
          ar = abs_i(tr);
          thl_q = step_throttle(thl_q, tl, spl_q);
          thr_r_q = step_throttle(thr_r_q, tr, spr_q);
          if (al < int'(thr_q) && ar < int'(thr_q)) begin
            rate = slow_q;
          end else begin
            dv = ((al + ar) / 2) * 15;
            rate = dv == 0 ? slow_q : 207000 / dv;
          end
          next_q = ms_q + rate;
          upd = 1'b1;
        end
      end
      ACT_R_EDGE: measure_wheel(er_q, spr_q, dr_q, thr_r_q, r.capture_count);
      ACT_L_EDGE: measure_wheel(el_q, spl_q, dl_q, thl_q, r.capture_count);
      ACT_R_OVF: er_q = add_overflow(er_q);
      ACT_L_OVF: el_q = add_overflow(el_q);
      ACT_CLEAR: begin
        dl_q = 0;
        dr_q = 0;
      end
      default: ;
    endcase
    e.pwm_left = pwm_of(-thl_q);
    e.pwm_right = pwm_of(thr_r_q);
    e.throttle_left_out = thl_q[7:0];
    e.throttle_right_out = thr_r_q[7:0];
    e.speed_left_out = spl_q[15:0];
    e.speed_right_out = spr_q[15:0];
    e.distance_left_out = dl_q[15:0];
    e.distance_right_out = dr_q[15:0];
    e.throttle_updated = upd;
    wheel_rsp_q.push_back(e);
  endtask

  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_data_i <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_wheels(r);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] v);
    while (wheel_rsp_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LIMIT: lim_q = v & 16'h7F;
      REG_REV: rev_q = v & 16'hFF;
      REG_FWD: fwd_q = v & 16'hFF;
      REG_SLOW: slow_q = v;
      default: thr_q = v & 16'h3FF;
    endcase
  endtask

  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d actual %0d", name, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t e;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_valid_o && out_ready_i) begin
      if (wheel_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result");
      end else begin
        e = wheel_rsp_q.pop_front();
        check_field("pwm_left", e.pwm_left, out_data_o.pwm_left);
        check_field("pwm_right", e.pwm_right, out_data_o.pwm_right);
        check_field("throttle_left", e.throttle_left_out, out_data_o.throttle_left_out);
        check_field("throttle_right", e.throttle_right_out, out_data_o.throttle_right_out);
        check_field("speed_left", e.speed_left_out, out_data_o.speed_left_out);
        check_field("speed_right", e.speed_right_out, out_data_o.speed_right_out);
        check_field("distance_left", e.distance_left_out, out_data_o.distance_left_out);
        check_field("distance_right", e.distance_right_out, out_data_o.distance_right_out);
        check_field("updated", e.throttle_updated, out_data_o.throttle_updated);
      end
    end
    if (idle_cycles > 200000) begin
      $display("[wheel_speed_throttle_loop] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  function automatic req_t make_req(action_e a, logic [15:0] cap, logic [15:0] tl,
                                    logic [15:0] tr);
    req_t r;
    r.action = a;
    r.capture_count = cap;
    r.target_left_speed = tl;
    r.target_right_speed = tr;
    return r;
  endfunction

  function automatic logic [15:0] rand_target();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 400)) - 200);
      2: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  function automatic req_t rand_req();
    int unsigned k;
    logic [15:0] cap;
    logic [15:0] r0, r1, r2;
    k = $urandom_range(99);
    cap = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    r0 = 16'($urandom);
    r1 = 16'($urandom);
    r2 = 16'($urandom);
    if (k < 45) return make_req(ACT_TICK, r0, rand_target(), rand_target());
    if (k < 60) return make_req(ACT_R_EDGE, cap, r1, r2);
    if (k < 75) return make_req(ACT_L_EDGE, cap, r1, r2);
    if (k < 84) return make_req(ACT_R_OVF, r0, r1, r2);
    if (k < 93) return make_req(ACT_L_OVF, r0, r1, r2);
    if (k < 96) return make_req(ACT_CLEAR, r0, r1, r2);
    return make_req(action_e'(3'($urandom_range(6, 7))), r0, r1, r2);
  endfunction

  task automatic test_directed();
    send_request(make_req(ACT_L_EDGE, 16'h0000, '0, '0));
    send_request(make_req(ACT_R_EDGE, 16'hFFFF, '0, '0));
    send_request(make_req(ACT_TICK, '0, 16'h7FFF, 16'h8000));
    send_request(make_req(ACT_TICK, '0, 16'h8000, 16'h7FFF));
    repeat (3) send_request(make_req(ACT_L_OVF, '0, '0, '0));
    send_request(make_req(ACT_L_EDGE, 16'h0601, '0, '0));
    send_request(make_req(ACT_R_OVF, '0, '0, '0));
    send_request(make_req(ACT_R_EDGE, 16'h05FF, '0, '0));
    send_request(make_req(ACT_CLEAR, '0, '0, '0));
    send_request(make_req(ACT_RSVD6, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_req(ACT_RSVD7, '0, '0, '0));
    repeat (4) send_request(make_req(ACT_TICK, 16'hFFFF, 16'h0001, 16'hFFFF));
    repeat (3) send_request(make_req(ACT_TICK, '0, 16'h0064, 16'hFF9C));
  endtask

  task automatic test_saturation();
    repeat (40) send_request(make_req(ACT_L_OVF, '0, '0, '0));
    send_request(make_req(ACT_L_EDGE, 16'hFFFF, '0, '0));
    repeat (40) send_request(make_req(ACT_R_EDGE, 16'($urandom), '0, '0));
  endtask

  task automatic test_random(int n);
    repeat (n) send_request(rand_req());
  endtask

  task automatic test_config_sweep();
    write_reg(REG_LIMIT, 16'd0);
    test_random(100);
    write_reg(REG_LIMIT, 16'hFFFF);
    write_reg(REG_REV, 16'd255);
    write_reg(REG_FWD, 16'd0);
    write_reg(REG_SLOW, 16'd1);
    write_reg(REG_THRESH, 16'd1000);
    test_random(250);
    write_reg(REG_LIMIT, 16'd1);
    write_reg(REG_REV, 16'd0);
    write_reg(REG_FWD, 16'd255);
    write_reg(REG_SLOW, 16'hFFFF);
    write_reg(REG_THRESH, 16'd0);
    test_random(150);
    write_reg(REG_LIMIT, 16'd5);
    write_reg(REG_SLOW, 16'd3);
    write_reg(REG_THRESH, 16'hFFFF);
    test_random(200);
    write_reg(REG_LIMIT, 16'd100);
    write_reg(REG_REV, 16'd62);
    write_reg(REG_FWD, 16'd125);
    write_reg(REG_SLOW, 16'd2);
    write_reg(REG_THRESH, 16'd2);
    test_random(200);
  endtask

  initial begin
    lim_q = 100; rev_q = 62; fwd_q = 125; slow_q = 500; thr_q = 2;
    ms_q = '0; next_q = '0; thl_q = 0; thr_r_q = 0; spl_q = 0; spr_q = 0;
    el_q = '0; er_q = '0; dl_q = 0; dr_q = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 18; recv_idle_pct = 66;
    test_directed();
    test_random(100);
    test_config_sweep();
    send_idle_pct = 66; recv_idle_pct = 18;
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(300);
    test_saturation();
    while (wheel_rsp_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (mismatches == 0) $display("[wheel_speed_throttle_loop] OK");
    else $display("[wheel_speed_throttle_loop] ERROR");
    $finish;
  end
endmodule
